FILE: rtl/three_queue_burst_round_robin_core_assert.svh
// Assertion macros shared by the three-lane burst round-robin queue.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef THREE_QUEUE_BURST_ROUND_ROBIN_CORE_ASSERT_SVH
`define THREE_QUEUE_BURST_ROUND_ROBIN_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define TQBR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define TQBR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define TQBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tqbr_pkg.sv
// Shared types and constants of the three-lane burst round-robin queue.
// No dependencies; used by the interfaces, the lane controller and the top level.
package tqbr_pkg;

	localparam int LANE_DEPTH_DEF = 128;
	localparam int LANE_COUNT     = 3;
	localparam int WORD_W         = 32;
	localparam int BURST_W        = 4;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	localparam logic [1:0]         LANE_LAST   = 2'(LANE_COUNT - 1);
	localparam logic [BURST_W-1:0] BURST_RESET = 4'd3;

	// Register index, taken from paddr[2] (registers sit 4 bytes apart).
	localparam logic [0:0] REG_BURST_LENGTH = 1'b0;

	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_SERVE = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [1:0]         lane;
		logic signed [31:0] value;
	} item_t;

	// Result flags produced by the lane controller for one item.
	typedef struct packed {
		logic       out_valid;
		logic [1:0] out_lane;
		logic       push_dropped;
		logic       all_empty;
	} res_flags_t;

	function automatic logic [1:0] lane_next(input logic [1:0] l);
		lane_next = (l >= LANE_LAST) ? 2'd0 : l + 2'd1;
	endfunction

endpackage

FILE: rtl/tqbr_ifs.sv
// Valid/ready channel interfaces for the item input and the result output.
// Depends on tqbr_pkg for the payload types.
interface tqbr_item_if import tqbr_pkg::*; ();
	logic               valid;
	logic               ready;
	action_t            action;
	logic [1:0]         lane;
	logic signed [31:0] value;

	modport source (output valid, output action, output lane, output value, input ready);
	modport sink (input valid, input action, input lane, input value, output ready);
endinterface

interface tqbr_result_if import tqbr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               out_valid;
	logic signed [31:0] out_value;
	logic [1:0]         out_lane;
	logic               push_dropped;
	logic               all_empty;

	modport source (output valid, output out_valid, output out_value, output out_lane,
		output push_dropped, output all_empty, input ready);
	modport sink (input valid, input out_valid, input out_value, input out_lane,
		input push_dropped, input all_empty, output ready);
endinterface

FILE: rtl/tqbr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tqbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/tqbr_ctrl.sv
// Lane controller: head pointers, fill counts and the burst round-robin scheduler.
// Depends on tqbr_pkg and the assertion macro header; drives the lane RAM ports.
`include "three_queue_burst_round_robin_core_assert.svh"

module tqbr_ctrl import tqbr_pkg::*; #(
	parameter int LANE_DEPTH = LANE_DEPTH_DEF,
	localparam int AW = $clog2(LANE_COUNT * LANE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  item_t              item,
	input  logic [BURST_W-1:0] burst_length,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output logic               ram_re,
	output logic [AW-1:0]      ram_raddr,
	output res_flags_t         flags
);

	localparam int HW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
	localparam int FW = $clog2(LANE_DEPTH + 1);

	logic [HW-1:0]      head_q [LANE_COUNT];
	logic [FW-1:0]      fill_q [LANE_COUNT];
	logic [1:0]         cur_q;
	logic [BURST_W-1:0] burst_q;

	logic [HW-1:0]      head_nx [LANE_COUNT];
	logic [FW-1:0]      fill_nx [LANE_COUNT];
	logic [1:0]         cur_nx;
	logic [BURST_W-1:0] burst_nx;

	logic [LANE_COUNT-1:0] nonempty;
	logic                  any_ne;
	logic [1:0]            cand1, cand2, pick;
	logic                  is_serve, serve_go;
	logic                  lane_ok, push_full, push_go;
	logic [1:0]            push_lane;
	logic [FW:0]           slot_sum;
	logic [HW-1:0]         slot;
	logic [BURST_W-1:0]    taken_base;
	logic [BURST_W:0]      taken_nx;
	logic [BURST_W-1:0]    limit;
	logic                  burst_done;

	function automatic logic [AW-1:0] lane_base(input logic [1:0] l);
		case (l)
			2'd1:    lane_base = AW'(LANE_DEPTH);
			2'd2:    lane_base = AW'(2 * LANE_DEPTH);
			default: lane_base = '0;
		endcase
	endfunction

	always_comb begin
		for (int k = 0; k < LANE_COUNT; k++) begin
			nonempty[k] = fill_q[k] != '0;
		end
		any_ne = |nonempty;
		is_serve = item.action == ACT_SERVE;

		// Search from the lane in service onward for the first lane holding data.
		cand1 = lane_next(cur_q);
		cand2 = lane_next(cand1);
		if (nonempty[cur_q]) begin
			pick = cur_q;
		end else if (nonempty[cand1]) begin
			pick = cand1;
		end else begin
			pick = cand2;
		end
		serve_go = step && is_serve && any_ne;

		limit      = (burst_length == '0) ? BURST_W'(1) : burst_length;
		taken_base = (pick != cur_q) ? '0 : burst_q;
		taken_nx   = {1'b0, taken_base} + (BURST_W + 1)'(1);
		burst_done = (taken_nx >= {1'b0, limit}) || (fill_q[pick] == FW'(1));

		lane_ok   = item.lane <= LANE_LAST;
		push_lane = lane_ok ? item.lane : 2'd0;
		push_full = fill_q[push_lane] >= FW'(LANE_DEPTH);
		push_go   = step && !is_serve && lane_ok && !push_full;

		// Fill count is below the depth here, so one subtract wraps the slot.
		slot_sum = (FW + 1)'(head_q[push_lane]) + (FW + 1)'(fill_q[push_lane]);
		if (slot_sum >= (FW + 1)'(LANE_DEPTH)) begin
			slot = HW'(slot_sum - (FW + 1)'(LANE_DEPTH));
		end else begin
			slot = HW'(slot_sum);
		end

		ram_we    = push_go;
		ram_waddr = lane_base(push_lane) + AW'(slot);
		ram_re    = serve_go;
		ram_raddr = lane_base(pick) + AW'(head_q[pick]);

		for (int k = 0; k < LANE_COUNT; k++) begin
			head_nx[k] = head_q[k];
			fill_nx[k] = fill_q[k];
		end
		cur_nx   = cur_q;
		burst_nx = burst_q;
		if (push_go) begin
			fill_nx[push_lane] = fill_q[push_lane] + FW'(1);
		end
		if (serve_go) begin
			head_nx[pick] = (head_q[pick] == HW'(LANE_DEPTH - 1)) ? '0 : head_q[pick] + HW'(1);
			fill_nx[pick] = fill_q[pick] - FW'(1);
			if (burst_done) begin
				cur_nx   = lane_next(pick);
				burst_nx = '0;
			end else begin
				cur_nx   = pick;
				burst_nx = taken_nx[BURST_W-1:0];
			end
		end

		flags.out_valid    = serve_go;
		flags.out_lane     = serve_go ? pick : 2'd0;
		flags.push_dropped = !is_serve && !(lane_ok && !push_full);
		flags.all_empty    = 1'b1;
		for (int k = 0; k < LANE_COUNT; k++) begin
			if (fill_nx[k] != '0) begin
				flags.all_empty = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_COUNT; k++) begin
				head_q[k] <= '0;
				fill_q[k] <= '0;
			end
			cur_q   <= '0;
			burst_q <= '0;
		end else if (step) begin
			for (int k = 0; k < LANE_COUNT; k++) begin
				head_q[k] <= head_nx[k];
				fill_q[k] <= fill_nx[k];
			end
			cur_q   <= cur_nx;
			burst_q <= burst_nx;
		end
	end

	`TQBR_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q[0] <= FW'(LANE_DEPTH) && fill_q[1] <= FW'(LANE_DEPTH) && fill_q[2] <= FW'(LANE_DEPTH), "lane fill count exceeds lane depth")
	`TQBR_ASSERT_IMPLIES(a_read_nonempty, clk, arst_n, ram_re, fill_q[pick] != '0 && !ram_we, "serve reads an empty lane or collides with a push")
	`TQBR_ASSERT_NEXT(a_burst_restart, clk, arst_n, serve_go && burst_done, burst_q == '0, "burst count not cleared when service moves on")

endmodule

FILE: rtl/three_queue_burst_round_robin_core.sv
// Top level of the three-lane burst round-robin queue: channels, APB register, pipeline.
// Depends on tqbr_pkg, tqbr_ifs, tqbr_ram, tqbr_ctrl and the assertion macro header.

// One item (push or serve) is taken every clock cycle unless the result channel stalls,
// and each produces exactly one result: it passes the input register, where the lane
// controller updates pointers and drives the lane RAM, then the result register, which
// lines up with the RAM's registered read data. The lane RAM holds all three lanes
// (3 x LANE_DEPTH words) and needs no clearing after reset, as only written entries are
// ever read. burst_length is to be written through the APB port at address 0 while the
// block is idle (not enforced by the block); a value of zero acts as one.
`include "three_queue_burst_round_robin_core_assert.svh"

module three_queue_burst_round_robin_core import tqbr_pkg::*; #(
	parameter int LANE_DEPTH = LANE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	tqbr_item_if.sink           item,
	tqbr_result_if.source       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int AW = $clog2(LANE_COUNT * LANE_DEPTH);

	logic               item_v_s1;
	item_t              item_s1;
	logic               res_v_s2;
	res_flags_t         flags_s2;
	logic [BURST_W-1:0] burst_len_q;

	logic               advance;
	res_flags_t         flags;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;
	logic               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == REG_BURST_LENGTH;
	assign prdata  = reg_hit ? PDATA_W'(burst_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_len_q <= BURST_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			burst_len_q <= pwdata[BURST_W-1:0];
		end
	end

	// The input register moves on whenever the result register is free or being emptied.
	assign advance    = item_v_s1 && (!res_v_s2 || result.ready);
	assign item.ready = !item_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			res_v_s2  <= 1'b0;
		end else begin
			if (item.ready) begin
				item_v_s1 <= item.valid;
			end
			if (advance) begin
				res_v_s2 <= 1'b1;
			end else if (result.ready) begin
				res_v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action <= item.action;
			item_s1.lane   <= item.lane;
			item_s1.value  <= item.value;
		end
		if (advance) begin
			flags_s2 <= flags;
		end
	end

	tqbr_ctrl #(
		.LANE_DEPTH(LANE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.item         (item_s1),
		.burst_length (burst_len_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.flags        (flags)
	);

	tqbr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(LANE_COUNT * LANE_DEPTH)
	) u_lane_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item_s1.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result.valid        = res_v_s2;
	assign result.out_valid    = flags_s2.out_valid;
	assign result.out_value    = flags_s2.out_valid ? signed'(ram_rdata) : '0;
	assign result.out_lane     = flags_s2.out_lane;
	assign result.push_dropped = flags_s2.push_dropped;
	assign result.all_empty    = flags_s2.all_empty;

	`TQBR_ASSERT_IMPLIES(a_serve_not_dropped, clk, arst_n, res_v_s2 && flags_s2.out_valid, !flags_s2.push_dropped && !flags_s2.all_empty || flags_s2.all_empty && !flags_s2.push_dropped, "served result also flagged as a dropped push")
	`TQBR_ASSERT_NEXT(a_result_loaded, clk, arst_n, advance, res_v_s2, "result register not loaded after the input register moved on")

endmodule
